FILE: design/block_xor_reverse_decipher_assert.svh
// ----------------------------------------------------------------------------
// block xor reverse decipher assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef BLOCK_XOR_REVERSE_DECIPHER_ASSERT_SVH
`define BLOCK_XOR_REVERSE_DECIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define BXR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BXR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BXR_ASSERT(label, clk, rst_n, prop, msg)
`define BXR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: design/bxr_pkg.sv
// ----------------------------------------------------------------------------
// bxr_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bxr_pkg;

    localparam int BXR_CHUNK     = 20;
    localparam int BXR_KEY_DEPTH = 128;

    localparam int LEN_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int KIDX_W  = 7;
    localparam int IN_W    = 16;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_KEY  = 1'b1;

    typedef struct packed {
        logic take;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic key_op;
        logic flush;
        logic emit_done;
    } t_status;

endpackage

FILE: design/block_xor_reverse_decipher.sv
// ----------------------------------------------------------------------------
// block_xor_reverse_decipher
// xor decipher with per-block key restart and reversed block output
// ----------------------------------------------------------------------------
// A data word passes a key memory read, then an xor into the block
// buffer; a key write is done at the take. When a block closes, the input
// stalls while the block is read back from the buffer in reverse, one
// byte per cycle when the sink keeps tready high, through the registered
// read port. Throughput is set by the input stalling while the block
// drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_xor_reverse_decipher
    import bxr_pkg::*;
#(
    parameter int CHUNK     = BXR_CHUNK,
    parameter int KEY_DEPTH = BXR_KEY_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_W-1:0]   i_s_axis_tdata,   // data_byte, key_index, zero pad
    input  logic              i_s_axis_tlast,   // end_of_data
    input  logic              i_s_axis_tuser,   // operation
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // plain_byte
    output logic              o_m_axis_tlast,   // last_of_block
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata       // key_length
);

    t_cmd    cmd;
    t_status status;

    bxr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_s_ready (o_s_axis_tready)
    );

    bxr_datapath #(
        .CHUNK     (CHUNK),
        .KEY_DEPTH (KEY_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_s_axis_tuser),
        .i_data_byte  (i_s_axis_tdata[BYTE_W-1:0]),
        .i_key_index  (i_s_axis_tdata[BYTE_W+KIDX_W-1:BYTE_W]),
        .i_eod        (i_s_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_plain_byte (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

FILE: design/bxr_ram.sv
// ----------------------------------------------------------------------------
// bxr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bxr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bxr_ctrl.sv
// ----------------------------------------------------------------------------
// bxr_ctrl
// sequencer: take word, key lookup and xor, reversed block emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bxr_ctrl
    import bxr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_s_ready
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_s_ready = (r_state == S_IDLE);
    assign take      = o_s_ready && i_s_valid;

    always_comb begin
        o_cmd.take = take;
        o_cmd.step = (r_state == S_LOOKUP);
        o_cmd.emit = (r_state == S_EMIT);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && !i_status.key_op) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = i_status.flush ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/bxr_datapath.sv
// ----------------------------------------------------------------------------
// bxr_datapath
// key and block memories, fill and chunk counters, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "block_xor_reverse_decipher_assert.svh"

module bxr_datapath
    import bxr_pkg::*;
#(
    parameter int CHUNK     = BXR_CHUNK,
    parameter int KEY_DEPTH = BXR_KEY_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [KIDX_W-1:0] i_key_index,
    input  logic              i_eod,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_plain_byte,
    output logic              o_last
);

    localparam int FW = $clog2(CHUNK + 1);
    localparam int AW = (CHUNK > 1) ? $clog2(CHUNK) : 1;
    localparam int KW = $clog2(KEY_DEPTH);

    logic [BYTE_W-1:0] r_key_length;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_pos;
    logic [FW-1:0]     r_cnt;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eod;
    logic              r_kzero;
    logic              r_out_valid;
    logic              r_out_last;

    logic [LEN_W-1:0]  eff_len;
    logic [FW-1:0]     new_fill;
    logic [FW-1:0]     new_pos;
    logic              chunk_end;
    logic              flush;
    logic              out_fire;
    logic              issue;
    logic              key_we;
    logic              key_re;
    logic [KW-1:0]     key_addr;
    logic [BYTE_W-1:0] key_rdata;
    logic [BYTE_W-1:0] plain;

    // effective key length, zero reads as one, clamped to key depth
    always_comb begin
        eff_len = {1'b0, r_key_length};
        if (r_key_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (eff_len > LEN_W'(KEY_DEPTH)) begin
            eff_len = LEN_W'(KEY_DEPTH);
        end
    end

    assign new_fill  = r_fill + FW'(1);
    assign new_pos   = r_pos + FW'(1);
    assign chunk_end = (new_pos >= FW'(CHUNK));
    assign flush     = chunk_end || r_eod || (LEN_W'(new_fill) >= eff_len);

    assign out_fire = r_out_valid && i_ready;
    assign issue    = i_cmd.emit && (r_cnt != '0) && (!r_out_valid || out_fire);

    assign key_we   = i_cmd.take && (i_op == OP_KEY) && (32'(i_key_index) < KEY_DEPTH);
    assign key_re   = i_cmd.take && (i_op == OP_DATA);
    assign key_addr = key_we ? KW'(i_key_index) : KW'(r_fill);

    assign plain = r_byte ^ (r_kzero ? '0 : key_rdata);

    bxr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_addr),
        .i_wdata (i_data_byte),
        .i_re    (key_re),
        .i_raddr (key_addr),
        .o_rdata (key_rdata)
    );

    bxr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CHUNK)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.step),
        .i_waddr (AW'(r_fill)),
        .i_wdata (plain),
        .i_re    (issue),
        .i_raddr (AW'(r_cnt - FW'(1))),
        .o_rdata (o_plain_byte)
    );

    always_ff @(posedge i_clk) begin
        if (key_re) begin
            r_byte  <= i_data_byte;
            r_eod   <= i_eod;
            r_kzero <= (32'(r_fill) >= KEY_DEPTH);
        end
        if (issue) begin
            r_out_last <= (r_cnt == FW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= BYTE_W'(1);
            r_fill       <= '0;
            r_pos        <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key_length <= i_cfg_wdata;
            end
            if (i_cmd.step) begin
                if (flush) begin
                    r_cnt  <= new_fill;
                    r_fill <= '0;
                end else begin
                    r_fill <= new_fill;
                end
                r_pos <= (chunk_end || r_eod) ? '0 : new_pos;
            end
            if (issue) begin
                r_cnt       <= r_cnt - FW'(1);
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.key_op    = (i_op == OP_KEY);
        o_status.flush     = flush;
        o_status.emit_done = out_fire && r_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_last  = r_out_last;

    `BXR_ASSERT(a_no_write_while_out, i_clk, i_rst_n, i_cmd.step |-> !r_out_valid, "block write while output pending")
    `BXR_ASSERT(a_fill_within_chunk, i_clk, i_rst_n, (r_fill <= r_pos) && (32'(r_pos) < CHUNK), "fill or chunk position out of range")
    `BXR_ASSERT(a_last_drains, i_clk, i_rst_n, (r_out_valid && r_out_last) |-> (r_cnt == '0), "last byte shown with bytes left")

endmodule
